[design/bssc_pkg.sv]
// shared constants, codes and types for the soc scale and smooth block
package bssc_pkg;

    localparam int PCT_W      = 7;
    localparam int LIVE_W     = 15;
    localparam int ARG_W      = 8;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // divider operand width and step counter width
    localparam int DIV_W     = LIVE_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [CMD_W-1:0] CMD_REPORT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FULL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SETMAX = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SOC_FLOOR     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MARGIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_EN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DYN_SCALE_EN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ATOMIC_EN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_ABN_EN   = 3'd6;

    localparam logic [PCT_W-1:0]  PCT_FULL   = 7'd100;
    localparam logic [PCT_W-1:0]  PCT_TRIM   = 7'd99;
    localparam logic [LIVE_W-1:0] LIVE_RESET = 15'd100;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[design/bssc_div.sv]
// restoring divider, one quotient bit per cycle
module bssc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bssc_pkg::DIV_W-1:0]  dividend,
    input  logic [bssc_pkg::DIV_W-1:0]  divisor,
    output logic [bssc_pkg::DIV_W-1:0]  quotient,
    output bssc_pkg::div_stat_t         stat
);
    import bssc_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     den_reg;

    logic [DIV_W:0]       shifted;
    logic [DIV_W+1:0]     diff;
    logic                 fits;
    logic [DIV_W-1:0]     rem_next;
    logic [DIV_W-1:0]     quo_next;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DIV_W-1]};
        diff     = {1'b0, shifted} - {2'b00, den_reg};
        fits     = !diff[DIV_W+1];
        rem_next = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        quo_next = {quo_reg[DIV_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[design/battery_soc_scale_and_smooth.sv]
// top level: battery state of charge scaler and smoother
// Takes one command word at a time and answers each with one result word.
// A report command scales the raw reading between soc_floor and the live
// maximum, clamps it to 0..100 and then smooths it against the last reported
// value; charge full rederives the live maximum; set max clamps a requested
// maximum. A word that goes through the divider (an error-free scaled report
// at or above the floor with a positive denominator, or charge full with
// dynamic scaling) forms its operands through a single constant multiplier
// and starts the shared restoring divider, runs 15 divider steps, picks up
// the quotient on the done flag, and then smooths and updates the state.
// Every other word goes from operand forming straight to the update step.
// in_ready is high only while the sequencer is idle and comes back together
// with the result. A finished result sits in the output register, so the
// next word may be accepted before it is taken; that word then waits in its
// update step, with in_ready low, until the output register is free.
module battery_soc_scale_and_smooth (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [bssc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bssc_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input word
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [bssc_pkg::CMD_W-1:0]          command,
    input  logic [bssc_pkg::PCT_W-1:0]          raw_soc,
    input  logic                                soc_read_error,
    input  logic [bssc_pkg::ARG_W-1:0]          argument,
    input  logic                                charging,
    // result word
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bssc_pkg::PCT_W-1:0]          capacity_pct,
    output logic [bssc_pkg::LIVE_W-1:0]         live_max,
    output logic                                scale_fault
);
    import bssc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_POST
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [PCT_W-1:0]  soc_floor_reg;
    logic [PCT_W-1:0]  nominal_max_reg;
    logic [PCT_W-1:0]  max_margin_reg;
    logic              scale_en_reg;
    logic              dyn_scale_en_reg;
    logic              atomic_en_reg;
    logic              skip_abn_en_reg;

    // block state
    logic [PCT_W-1:0]  last_cap_reg;
    logic              resync_reg;
    logic [LIVE_W-1:0] live_reg;

    // latched input word
    logic [CMD_W-1:0]  cmd_reg;
    logic [PCT_W-1:0]  raw_reg;
    logic              err_reg;
    logic [ARG_W-1:0]  arg_reg;
    logic              chg_reg;

    // intermediate result (direct value from operand forming, or quotient)
    logic [LIVE_W-1:0] res_reg;
    logic              fault_reg;

    // output register
    logic              out_valid_reg;
    logic [PCT_W-1:0]  capacity_pct_reg;
    logic [LIVE_W-1:0] live_max_reg;
    logic              scale_fault_reg;

    // shared divider
    logic              div_start;
    logic [DIV_W-1:0]  div_num;
    logic [DIV_W-1:0]  div_den;
    logic [DIV_W-1:0]  div_quo;
    div_stat_t         div_stat;

    // operand stage signals
    logic signed [PCT_W+1:0] lo_s;       // nominal minus margin, may go negative
    logic [PCT_W:0]    hi;               // nominal plus margin
    logic [PCT_W:0]    lo_pos;           // lower bound floored at zero
    logic [PCT_W:0]    full_m;
    logic [ARG_W-1:0]  cap;
    logic              cap_is_full;
    logic [PCT_W-1:0]  span;
    logic              below_floor;
    logic [LIVE_W:0]   den_wide;
    logic              den_bad;
    logic              scaling;
    logic [PCT_W:0]    mul_a;
    logic [PCT_W-1:0]  mul_k;
    logic [LIVE_W-1:0] mul_out;
    logic [ARG_W-1:0]  set_m;
    logic              need_div;
    logic [LIVE_W-1:0] res_prep;
    logic              fault_prep;

    // post stage signals
    logic [PCT_W-1:0]  rep_v;
    logic [PCT_W-1:0]  smooth_v;
    logic [PCT_W-1:0]  cap_sat;
    logic [PCT_W-1:0]  last_next;
    logic              resync_next;
    logic [LIVE_W-1:0] live_next;
    logic [PCT_W-1:0]  pct_next;
    logic              post_fire;

    bssc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // window around the nominal maximum
    always_comb
    begin
        lo_s   = $signed({2'b00, nominal_max_reg}) - $signed({2'b00, max_margin_reg});
        hi     = {1'b0, nominal_max_reg} + {1'b0, max_margin_reg};
        lo_pos = lo_s[PCT_W+1] ? '0 : lo_s[PCT_W:0];
    end

    // operand forming: one constant multiplier shared between report and charge full
    always_comb
    begin
        // charge full: reading clamped into the window, a read error picks the low end
        if (err_reg || ($signed({2'b00, raw_reg}) < lo_s))
            full_m = lo_pos;
        else if ({1'b0, raw_reg} > hi)
            full_m = hi;
        else
            full_m = {1'b0, raw_reg};

        cap         = (arg_reg == '0) ? ARG_W'(1) : arg_reg;
        cap_is_full = (cap == {1'b0, PCT_FULL});

        // report: offset from the floor and scaling denominator
        below_floor = raw_reg < soc_floor_reg;
        span        = raw_reg - soc_floor_reg;
        den_wide    = {1'b0, live_reg} - (LIVE_W+1)'(soc_floor_reg);
        den_bad     = den_wide[LIVE_W] || (den_wide == '0);
        scaling     = scale_en_reg || dyn_scale_en_reg;

        if (cmd_reg == CMD_FULL)
        begin
            mul_a = full_m;
            mul_k = cap_is_full ? PCT_TRIM : PCT_FULL;
        end
        else
        begin
            mul_a = {1'b0, span};
            mul_k = PCT_FULL;
        end
        mul_out = LIVE_W'({7'b0, mul_a} * {8'b0, mul_k});

        // set max: out-of-range request gives full, otherwise clamp to the window
        if (arg_reg > {1'b0, PCT_FULL})
            set_m = {1'b0, PCT_FULL};
        else if ($signed({1'b0, arg_reg}) < lo_s)
            set_m = lo_pos;
        else if (arg_reg > hi)
            set_m = hi;
        else
            set_m = arg_reg;

        need_div   = 1'b0;
        res_prep   = '0;
        fault_prep = 1'b0;
        div_num    = mul_out;
        div_den    = LIVE_W'(PCT_FULL);

        unique case (cmd_reg)
            CMD_REPORT:
            begin
                if (err_reg)
                    res_prep = '0;
                else if (!scaling)
                    res_prep = LIVE_W'(raw_reg);
                else if (below_floor)
                    res_prep = '0;
                else if (den_bad)
                begin
                    res_prep   = LIVE_W'(PCT_FULL);
                    fault_prep = 1'b1;
                end
                else
                begin
                    need_div = 1'b1;
                    div_den  = den_wide[LIVE_W-1:0];
                end
            end
            CMD_FULL:
            begin
                need_div = dyn_scale_en_reg;
                div_den  = cap_is_full ? LIVE_W'(PCT_FULL) : LIVE_W'(cap);
            end
            CMD_SETMAX:
            begin
                res_prep = LIVE_W'(set_m);
            end
            default:
            begin
                res_prep = '0;
            end
        endcase

        div_start = (state_reg == S_PREP) && need_div;
    end

    // smoothing and state update
    always_comb
    begin
        rep_v = (res_reg > LIVE_W'(PCT_FULL)) ? PCT_FULL : res_reg[PCT_W-1:0];

        // one percent step toward the new value
        smooth_v = rep_v;
        if (atomic_en_reg)
        begin
            if (last_cap_reg < rep_v)
                smooth_v = last_cap_reg + 1'b1;
            else if (last_cap_reg > rep_v)
                smooth_v = last_cap_reg - 1'b1;
        end
        // no rise while running on battery
        if (skip_abn_en_reg && !chg_reg && (last_cap_reg < smooth_v))
            smooth_v = last_cap_reg;

        cap_sat = (cap >= {1'b0, PCT_FULL}) ? PCT_FULL : cap[PCT_W-1:0];

        last_next   = last_cap_reg;
        resync_next = resync_reg;
        live_next   = live_reg;
        pct_next    = last_cap_reg;

        unique case (cmd_reg)
            CMD_REPORT:
            begin
                if (resync_reg || err_reg)
                begin
                    // take the value outright
                    last_next   = rep_v;
                    resync_next = 1'b0;
                    pct_next    = rep_v;
                end
                else if (atomic_en_reg || skip_abn_en_reg)
                begin
                    last_next = smooth_v;
                    pct_next  = smooth_v;
                end
                else
                begin
                    pct_next = rep_v;
                end
            end
            CMD_FULL:
            begin
                if (dyn_scale_en_reg)
                begin
                    resync_next = resync_reg || err_reg;
                    live_next   = res_reg;
                    last_next   = cap_sat;
                    pct_next    = cap_sat;
                end
            end
            CMD_SETMAX:
            begin
                live_next   = res_reg;
                resync_next = 1'b1;
            end
            default:
            begin
                pct_next = last_cap_reg;
            end
        endcase

        post_fire = (state_reg == S_POST) && (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            soc_floor_reg    <= '0;
            nominal_max_reg  <= PCT_FULL;
            max_margin_reg   <= '0;
            scale_en_reg     <= 1'b0;
            dyn_scale_en_reg <= 1'b0;
            atomic_en_reg    <= 1'b0;
            skip_abn_en_reg  <= 1'b0;
            last_cap_reg     <= '0;
            resync_reg       <= 1'b1;
            live_reg         <= LIVE_RESET;
            out_valid_reg    <= 1'b0;
            capacity_pct_reg <= '0;
            live_max_reg     <= '0;
            scale_fault_reg  <= 1'b0;
            cmd_reg          <= CMD_REPORT;
            raw_reg          <= '0;
            err_reg          <= 1'b0;
            arg_reg          <= '0;
            chg_reg          <= 1'b0;
            res_reg          <= '0;
            fault_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SOC_FLOOR:    soc_floor_reg    <= cfg_data;
                    REG_NOMINAL_MAX:  nominal_max_reg  <= cfg_data;
                    REG_MAX_MARGIN:   max_margin_reg   <= cfg_data;
                    REG_SCALE_EN:     scale_en_reg     <= cfg_data[0];
                    REG_DYN_SCALE_EN: dyn_scale_en_reg <= cfg_data[0];
                    REG_ATOMIC_EN:    atomic_en_reg    <= cfg_data[0];
                    REG_SKIP_ABN_EN:  skip_abn_en_reg  <= cfg_data[0];
                    default:          ;
                endcase
            end

            // output register: load a finished word, else drop it once taken
            if (post_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg   <= command;
                        raw_reg   <= raw_soc;
                        err_reg   <= soc_read_error;
                        arg_reg   <= argument;
                        chg_reg   <= charging;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    res_reg   <= res_prep;
                    fault_reg <= fault_prep;
                    state_reg <= need_div ? S_DIV : S_POST;
                end
                S_DIV:
                begin
                    if (div_stat.done)
                    begin
                        res_reg   <= div_quo;
                        state_reg <= S_POST;
                    end
                end
                S_POST:
                begin
                    if (post_fire)
                    begin
                        last_cap_reg     <= last_next;
                        resync_reg       <= resync_next;
                        live_reg         <= live_next;
                        capacity_pct_reg <= pct_next;
                        live_max_reg     <= live_next;
                        scale_fault_reg  <= fault_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign capacity_pct = capacity_pct_reg;
    assign live_max     = live_max_reg;
    assign scale_fault  = scale_fault_reg;

    // the sequencer never takes a word while the divider is running
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> !in_ready)
        else $error("word accepted while divider busy");

    // a reported capacity never exceeds full scale
    a_pct_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (capacity_pct <= PCT_FULL))
        else $error("capacity above full scale");

    // a finished division is always followed by the update step
    a_done_to_post: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |=> (state_reg == S_POST))
        else $error("divider result not consumed");

endmodule

[tb/battery_soc_scale_and_smooth_test.sv]
// testbench for the battery soc scale and smooth block: directed table, then random phases
module battery_soc_scale_and_smooth_test;
    import bssc_pkg::*;

    // command 3 has no meaning: the block answers with its current state
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASES         = 8;
    localparam int PHASE_WORDS    = 120;
    localparam int MAX_REPORTED   = 10;

    // one command word as it goes into the block
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [PCT_W-1:0] raw;
        logic             err;
        logic [ARG_W-1:0] arg;
        logic             chg;
    } gauge_word_t;

    // one result word as it comes out of the block
    typedef struct packed {
        logic [PCT_W-1:0]  pct;
        logic [LIVE_W-1:0] live;
        logic              fault;
    } gauge_result_t;

    // directed row: either a register write or a command word, the latter
    // optionally with a hand-typed result
    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        gauge_word_t           word;
        logic                  typed;
        gauge_result_t         want;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [CMD_W-1:0]      command;
    logic [PCT_W-1:0]      raw_soc;
    logic                  soc_read_error;
    logic [ARG_W-1:0]      argument;
    logic                  charging;
    logic                  out_valid;
    logic                  out_ready;
    logic [PCT_W-1:0]      capacity_pct;
    logic [LIVE_W-1:0]     live_max;
    logic                  scale_fault;

    // shadow of the configuration registers, reset values
    int floor_r  = 0;
    int nom_r    = 100;
    int margin_r = 0;
    bit scale_r  = 1'b0;
    bit dyn_r    = 1'b0;
    bit atomic_r = 1'b0;
    bit skip_r   = 1'b0;

    // shadow of the smoothing state
    int last_cap = 0;
    bit resync   = 1'b1;
    int live_m   = 100;

    // results still owed by the block, oldest first
    gauge_result_t soc_expected_q[$];

    int mismatches   = 0;
    int quiet_cycles = 0;
    bit hold_request = 1'b0;
    bit send_burst   = 1'b0;
    bit recv_burst   = 1'b0;

    battery_soc_scale_and_smooth u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .raw_soc        (raw_soc),
        .soc_read_error (soc_read_error),
        .argument       (argument),
        .charging       (charging),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .capacity_pct   (capacity_pct),
        .live_max       (live_max),
        .scale_fault    (scale_fault)
    );

    // period of 2, rising edges at odd times
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // live maximum is kept in 0..32767
    function automatic int clamp_live(input int m);
        if (m < 0)
            return 0;
        if (m > 32767)
            return 32767;
        return m;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        case (idx)
            REG_SOC_FLOOR:    floor_r  = val & 'h7f;
            REG_NOMINAL_MAX:  nom_r    = val & 'h7f;
            REG_MAX_MARGIN:   margin_r = val & 'h7f;
            REG_SCALE_EN:     scale_r  = val[0];
            REG_DYN_SCALE_EN: dyn_r    = val[0];
            REG_ATOMIC_EN:    atomic_r = val[0];
            REG_SKIP_ABN_EN:  skip_r   = val[0];
            default: ;
        endcase
    endfunction

    // advances the shadow state by one command word and returns its result
    function automatic gauge_result_t advance_gauge(input gauge_word_t w);
        gauge_result_t r;
        int v;
        int den;
        int lo;
        int hi;
        int m;
        int cap;
        int raw_i;
        raw_i   = w.raw;
        lo      = nom_r - margin_r;
        hi      = nom_r + margin_r;
        r.fault = 1'b0;
        v       = last_cap;
        case (w.cmd)
            CMD_REPORT:
            begin
                if (w.err)
                begin
                    // failed read reports zero and forces a resync
                    v      = 0;
                    resync = 1'b1;
                end
                else
                begin
                    v = raw_i;
                    if (scale_r || dyn_r)
                    begin
                        if (v < floor_r)
                            v = 0;
                        else
                        begin
                            den = live_m - floor_r;
                            if (den <= 0)
                            begin
                                v       = PCT_FULL;
                                r.fault = 1'b1;
                            end
                            else
                                v = (v - floor_r) * 100 / den;
                        end
                    end
                end
                if (v > PCT_FULL)
                    v = PCT_FULL;
                if (v < 0)
                    v = 0;
                if (resync)
                begin
                    last_cap = v;
                    resync   = 1'b0;
                end
                else if (atomic_r || skip_r)
                begin
                    if (atomic_r)
                    begin
                        if (last_cap < v)
                            v = last_cap + 1;
                        else if (last_cap > v)
                            v = last_cap - 1;
                    end
                    if (skip_r && !w.chg && last_cap < v)
                        v = last_cap;
                    last_cap = v;
                end
            end
            CMD_FULL:
            begin
                if (dyn_r)
                begin
                    if (w.err)
                        resync = 1'b1;
                    if (w.err || raw_i < lo)
                        m = lo;
                    else if (raw_i > hi)
                        m = hi;
                    else
                        m = raw_i;
                    if (m < 0)
                        m = 0;
                    cap = w.arg;
                    if (cap == 0)
                        cap = 1;
                    if (cap != PCT_FULL)
                    begin
                        m        = m * 100 / cap;
                        last_cap = (cap > PCT_FULL) ? PCT_FULL : cap;
                    end
                    else
                    begin
                        m        = m * PCT_TRIM / 100;
                        last_cap = PCT_FULL;
                    end
                    live_m = clamp_live(m);
                end
                v = last_cap;
            end
            CMD_SETMAX:
            begin
                m = w.arg;
                if (m > PCT_FULL)
                    m = PCT_FULL;
                else if (m < lo)
                    m = lo;
                else if (m > hi)
                    m = hi;
                live_m = clamp_live(m);
                resync = 1'b1;
                v      = last_cap;
            end
            default: v = last_cap;
        endcase
        r.pct  = v[PCT_W-1:0];
        r.live = live_m[LIVE_W-1:0];
        return r;
    endfunction

    function automatic dir_row_t word_row(input logic [CMD_W-1:0] cmd, input int raw,
                                          input bit err, input int arg, input bit chg,
                                          input bit typed = 1'b0, input int pct = 0,
                                          input int live = 0, input bit fault = 1'b0);
        dir_row_t row;
        row            = '0;
        row.word.cmd   = cmd;
        row.word.raw   = raw[PCT_W-1:0];
        row.word.err   = err;
        row.word.arg   = arg[ARG_W-1:0];
        row.word.chg   = chg;
        row.typed      = typed;
        row.want.pct   = pct[PCT_W-1:0];
        row.want.live  = live[LIVE_W-1:0];
        row.want.fault = fault;
        return row;
    endfunction

    function automatic dir_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int data);
        dir_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = data[CFG_DATA_W-1:0];
        return row;
    endfunction

    // register write, taken at the next rising edge, then the enable drops
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        apply_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // stop offering words and wait until every owed result is back
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (soc_expected_q.size() != 0)
            @(posedge clk);
    endtask

    // offer one word after a random gap; predict its result once accepted
    task automatic send_word(input gauge_word_t w, input bit typed, input gauge_result_t want);
        int gap;
        gauge_result_t pred;
        // occasionally switch between gappy and back-to-back stretches
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 13);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        command        <= w.cmd;
        raw_soc        <= w.raw;
        soc_read_error <= w.err;
        argument       <= w.arg;
        charging       <= w.chg;
        in_valid       <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pred = advance_gauge(w);
        // typed rows still advance the shadow state, but the hand value is owed
        soc_expected_q.push_back(typed ? want : pred);
    endtask

    // result side: random stalls, one long hold on request, check against the queue
    initial
    begin : result_sink
        int stall;
        gauge_result_t want;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 39) == 0)
                recv_burst = !recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 13);
            if (hold_request)
            begin
                // long hold so the output register fills and in_ready drops
                hold_request = 1'b0;
                stall        = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            if (soc_expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("unexpected result word: pct %0d live %0d fault %0d",
                             capacity_pct, live_max, scale_fault);
            end
            else
            begin
                want = soc_expected_q.pop_front();
                if (capacity_pct !== want.pct || live_max !== want.live
                    || scale_fault !== want.fault)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTED)
                        $display({"result mismatch: want pct %0d live %0d fault %0d,",
                                  " got pct %0d live %0d fault %0d"},
                                 want.pct, want.live, want.fault,
                                 capacity_pct, live_max, scale_fault);
                end
            end
        end
    end

    // watchdog: too long without any word moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("battery_soc_scale_and_smooth_test failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        dir_row_t dir_rows[$];
        gauge_word_t w;
        gauge_result_t no_result;
        int pick;
        int raw_track;
        int floor_v;
        int nom_v;
        int margin_v;
        int scale_v;
        int dyn_v;
        int atomic_v;
        int skip_v;

        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        command        = CMD_REPORT;
        raw_soc        = '0;
        soc_read_error = 1'b0;
        argument       = '0;
        charging       = 1'b0;
        no_result      = '0;
        raw_track      = 50;

        // reset config: no scaling, no smoothing
        // first report after reset is taken outright
        dir_rows.push_back(word_row(CMD_REPORT, 57, 0, 0, 0, 1, 57, 100, 0));
        // no smoothing mode: reported as read, last value kept
        dir_rows.push_back(word_row(CMD_REPORT, 100, 0, 0, 1, 1, 100, 100, 0));
        dir_rows.push_back(word_row(CMD_REPORT, 0, 0, 255, 0, 1, 0, 100, 0));
        dir_rows.push_back(word_row(CMD_UNUSED, 100, 1, 255, 1, 1, 57, 100, 0));
        // charge full with dynamic scaling off changes nothing
        dir_rows.push_back(word_row(CMD_FULL, 80, 0, 50, 1, 1, 57, 100, 0));
        // requested max above 100 gives 100
        dir_rows.push_back(word_row(CMD_SETMAX, 0, 0, 255, 0, 1, 57, 100, 0));
        dir_rows.push_back(word_row(CMD_REPORT, 33, 0, 0, 0, 1, 33, 100, 0));
        // read error on report gives zero, taken outright
        dir_rows.push_back(word_row(CMD_REPORT, 99, 1, 0, 0, 1, 0, 100, 0));

        // dynamic scaling with both smoothing modes, window 85..95
        dir_rows.push_back(reg_row(REG_DYN_SCALE_EN, 1));
        dir_rows.push_back(reg_row(REG_SOC_FLOOR, 10));
        dir_rows.push_back(reg_row(REG_NOMINAL_MAX, 90));
        dir_rows.push_back(reg_row(REG_MAX_MARGIN, 5));
        dir_rows.push_back(reg_row(REG_ATOMIC_EN, 1));
        dir_rows.push_back(reg_row(REG_SKIP_ABN_EN, 1));
        dir_rows.push_back(word_row(CMD_REPORT, 5, 0, 0, 0));
        dir_rows.push_back(word_row(CMD_REPORT, 100, 0, 0, 1));
        dir_rows.push_back(word_row(CMD_REPORT, 100, 0, 0, 0));
        // capacity zero counts as one
        dir_rows.push_back(word_row(CMD_FULL, 80, 0, 0, 1, 1, 1, 8500, 0));
        // large capacity saturates last value at 100
        dir_rows.push_back(word_row(CMD_FULL, 100, 0, 255, 1));
        dir_rows.push_back(word_row(CMD_FULL, 90, 0, 100, 1));
        // read error on charge full uses the lower bound
        dir_rows.push_back(word_row(CMD_FULL, 127 & 100, 1, 42, 0));
        dir_rows.push_back(word_row(CMD_REPORT, 64, 0, 0, 0));
        dir_rows.push_back(word_row(CMD_SETMAX, 0, 0, 101, 0));
        dir_rows.push_back(word_row(CMD_SETMAX, 0, 0, 50, 1));

        // floor above the live maximum: non-positive denominator
        dir_rows.push_back(reg_row(REG_SOC_FLOOR, 100));
        dir_rows.push_back(word_row(CMD_REPORT, 100, 0, 0, 1, 1, 100, 85, 1));
        dir_rows.push_back(word_row(CMD_REPORT, 99, 0, 0, 0));

        // window -100..100: negative bounds end at zero
        dir_rows.push_back(reg_row(REG_NOMINAL_MAX, 0));
        dir_rows.push_back(reg_row(REG_MAX_MARGIN, 100));
        dir_rows.push_back(reg_row(REG_SOC_FLOOR, 0));
        dir_rows.push_back(word_row(CMD_FULL, 50, 1, 100, 0, 1, 100, 0, 0));
        dir_rows.push_back(word_row(CMD_REPORT, 50, 0, 0, 1, 1, 100, 0, 1));
        dir_rows.push_back(word_row(CMD_SETMAX, 0, 0, 0, 0));
        dir_rows.push_back(word_row(CMD_SETMAX, 0, 0, 100, 0));
        dir_rows.push_back(word_row(CMD_REPORT, 0, 0, 0, 0));

        // reset held, then released on a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
            begin
                settle_block();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end
            else
                send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
        end

        // random phases, each with every register rewritten while idle
        for (int p = 0; p < PHASES; p++)
        begin
            settle_block();
            case (p)
                // all smoothing on, plain 0..100 window
                0:
                begin
                    floor_v  = 0;
                    nom_v    = 100;
                    margin_v = 0;
                    scale_v  = 1;
                    dyn_v    = 1;
                    atomic_v = 1;
                    skip_v   = 1;
                end
                // all bounds at the top
                1:
                begin
                    floor_v  = 100;
                    nom_v    = 100;
                    margin_v = 100;
                    scale_v  = 1;
                    dyn_v    = 0;
                    atomic_v = 1;
                    skip_v   = 0;
                end
                // all bounds at the bottom
                2:
                begin
                    floor_v  = 0;
                    nom_v    = 0;
                    margin_v = 0;
                    scale_v  = 0;
                    dyn_v    = 1;
                    atomic_v = 0;
                    skip_v   = 0;
                end
                default:
                begin
                    // realistic windows first, any value in the last phases
                    floor_v  = (p >= 6) ? $urandom_range(0, 100) : $urandom_range(0, 30);
                    nom_v    = (p >= 6) ? $urandom_range(0, 100) : $urandom_range(60, 100);
                    margin_v = (p >= 6) ? $urandom_range(0, 100) : $urandom_range(0, 15);
                    scale_v  = $urandom_range(0, 1);
                    dyn_v    = $urandom_range(0, 1);
                    atomic_v = $urandom_range(0, 1);
                    skip_v   = $urandom_range(0, 1);
                end
            endcase
            write_reg(REG_SOC_FLOOR, floor_v);
            write_reg(REG_NOMINAL_MAX, nom_v);
            write_reg(REG_MAX_MARGIN, margin_v);
            write_reg(REG_SCALE_EN, scale_v);
            write_reg(REG_DYN_SCALE_EN, dyn_v);
            write_reg(REG_ATOMIC_EN, atomic_v);
            write_reg(REG_SKIP_ABN_EN, skip_v);
            if (p == 3)
                hold_request = 1'b1;

            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    w.cmd = CMD_REPORT;
                else if (pick < 80)
                    w.cmd = CMD_FULL;
                else if (pick < 95)
                    w.cmd = CMD_SETMAX;
                else
                    w.cmd = CMD_UNUSED;
                // mostly a slowly drifting reading, sometimes a jump or an extreme
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    raw_track = raw_track + $urandom_range(0, 6) - 3;
                else if (pick < 9)
                    raw_track = $urandom_range(0, 100);
                else
                    raw_track = $urandom_range(0, 1) ? 100 : 0;
                if (raw_track < 0)
                    raw_track = 0;
                if (raw_track > 100)
                    raw_track = 100;
                w.raw = raw_track[PCT_W-1:0];
                w.err = ($urandom_range(0, 11) == 0);
                w.chg = $urandom_range(0, 1);
                // capacities and maxima mostly near full, sometimes anything
                pick = $urandom_range(0, 7);
                if (pick == 0)
                    w.arg = $urandom_range(0, 255);
                else if (pick == 1)
                    w.arg = $urandom_range(0, 1) ? 8'd100 : 8'd0;
                else
                    w.arg = $urandom_range(40, 100);
                send_word(w, 1'b0, no_result);
            end
        end

        settle_block();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("battery_soc_scale_and_smooth_test passed");
        else
            $display("battery_soc_scale_and_smooth_test failed");
        $finish;
    end

endmodule

[battery_soc_scale_and_smooth.f]
design/bssc_pkg.sv
design/bssc_div.sv
design/battery_soc_scale_and_smooth.sv
tb/battery_soc_scale_and_smooth_test.sv
